### sv/hspc_pkg.sv
`default_nettype none
package hspc_pkg;

	// item codes
	localparam logic [1:0] FUNC_TICK         = 2'd0;
	localparam logic [1:0] FUNC_MEASURE_DONE = 2'd1;
	localparam logic [1:0] FUNC_READ_DONE    = 2'd2;

	// bus operation codes
	localparam logic [1:0] REQ_NONE    = 2'd0;
	localparam logic [1:0] REQ_MEASURE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	// register indexes
	localparam logic [1:0] REG_RETRY_DELAY   = 2'd0;
	localparam logic [1:0] REG_MEASURE_DELAY = 2'd1;
	localparam logic [1:0] REG_WAIT_DELAY    = 2'd2;
	localparam logic [1:0] REG_RETRY_LIMIT   = 2'd3;

	localparam logic [15:0] RETRY_DELAY_RST   = 16'd100;
	localparam logic [15:0] MEASURE_DELAY_RST = 16'd50;
	localparam logic [15:0] WAIT_DELAY_RST    = 16'd1000;
	localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd3;

	localparam int RAW_W = 14;
	localparam logic [RAW_W-1:0] FIELD_MAX = 14'h3fff;
	localparam logic [1:0] STATUS_FIRST  = 2'd0;
	localparam logic [1:0] STATUS_SECOND = 2'd1;
	localparam logic [7:0] FAIL_MAX = 8'hff;

	localparam logic [23:0] HUM_SCALE  = 24'd1000;
	localparam logic [24:0] TEMP_SCALE = 25'd1650;
	localparam logic [11:0] TEMP_OFFSET = 12'd400;

	typedef struct packed {
		logic [1:0]  func;
		logic        bus_status;
		logic [31:0] first_frame;
		logic [31:0] second_frame;
	} in_t;

	typedef struct packed {
		logic [1:0]         request;
		logic               new_reading;
		logic               reading_valid;
		logic [9:0]         humidity_tenths;
		logic signed [11:0] temperature_tenths;
	} out_t;

	typedef struct packed {
		logic             valid;
		logic [RAW_W-1:0] hum_raw;
		logic [RAW_W-1:0] temp_raw;
	} reading_t;

endpackage
`default_nettype wire

### sv/hspc_scale.sv
`default_nettype none
module hspc_scale (
	input  hspc_pkg::reading_t  reading,
	output logic [9:0]          humidity_tenths,
	output logic signed [11:0]  temperature_tenths
);
	import hspc_pkg::*;

	// divide by 2^14-1: quotient estimate from the high bits, one correction
	logic [23:0] hum_prod;
	logic [9:0]  hum_q0;
	logic [14:0] hum_r0;
	logic [9:0]  hum_q;
	logic [24:0] temp_prod;
	logic [10:0] temp_q0;
	logic [14:0] temp_r0;
	logic [10:0] temp_q;

	assign hum_prod = 24'(reading.hum_raw) * HUM_SCALE;
	assign hum_q0   = hum_prod[23:14];
	assign hum_r0   = 15'(hum_prod[13:0]) + 15'(hum_q0);
	assign hum_q    = hum_q0 + 10'(hum_r0 >= 15'(FIELD_MAX));

	assign temp_prod = 25'(reading.temp_raw) * TEMP_SCALE;
	assign temp_q0   = temp_prod[24:14];
	assign temp_r0   = 15'(temp_prod[13:0]) + 15'(temp_q0);
	assign temp_q    = temp_q0 + 11'(temp_r0 >= 15'(FIELD_MAX));

	always_comb begin
		if (reading.valid) begin
			humidity_tenths    = hum_q;
			temperature_tenths = signed'({1'b0, temp_q} - TEMP_OFFSET);
		end else begin
			humidity_tenths    = '0;
			temperature_tenths = '0;
		end
	end

endmodule
`default_nettype wire

### sv/humidity_sensor_poll_controller.sv
// pipeline: a request is held in the input register, then its result in the
// output register, which keeps the input open while its result is being taken
// throughput: one request per cycle while out_ready is high, set by the single
// update stage that both reads and writes the poll state
// reset: arst_n clears the poll state, the stored reading and both pipeline
// valids, and loads the delay and limit registers with their defaults
`default_nettype none
module humidity_sensor_poll_controller (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  hspc_pkg::in_t      in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output hspc_pkg::out_t     out_data,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import hspc_pkg::*;

	// configuration registers
	logic [15:0] retry_delay_q;
	logic [15:0] measure_delay_q;
	logic [15:0] wait_delay_q;
	logic [7:0]  retry_limit_q;

	// poll state
	logic [15:0]      countdown_q;
	logic             read_next_q;
	logic             pending_q;
	logic             valid_flag_q;
	logic [7:0]       failure_count_q;
	logic [RAW_W-1:0] hum_raw_q;
	logic [RAW_W-1:0] temp_raw_q;

	// pipeline registers
	logic  valid_s1;
	in_t   in_s1;
	logic  out_valid_s2;
	out_t  out_s2;

	// next state from the request in stage 1
	logic [15:0]      countdown_c;
	logic [15:0]      countdown_dec;
	logic             read_next_c;
	logic             pending_c;
	logic             valid_flag_c;
	logic [7:0]       failure_count_c;
	logic [RAW_W-1:0] hum_raw_c;
	logic [RAW_W-1:0] temp_raw_c;
	logic [1:0]       req_c;
	logic             fresh_c;
	logic             retry_c;
	logic             check_ok;
	reading_t         reading_c;
	logic [9:0]       hum_tenths_c;
	logic signed [11:0] temp_tenths_c;
	out_t             result_c;

	logic advance;
	logic cfg_write;

	// ---------------------------------------------------------------
	// register port, zero wait states
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_delay_q   <= RETRY_DELAY_RST;
			measure_delay_q <= MEASURE_DELAY_RST;
			wait_delay_q    <= WAIT_DELAY_RST;
			retry_limit_q   <= RETRY_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_RETRY_DELAY:   retry_delay_q   <= pwdata[15:0];
				REG_MEASURE_DELAY: measure_delay_q <= pwdata[15:0];
				REG_WAIT_DELAY:    wait_delay_q    <= pwdata[15:0];
				REG_RETRY_LIMIT:   retry_limit_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RETRY_DELAY:   prdata = 32'(retry_delay_q);
			REG_MEASURE_DELAY: prdata = 32'(measure_delay_q);
			REG_WAIT_DELAY:    prdata = 32'(wait_delay_q);
			REG_RETRY_LIMIT:   prdata = 32'(retry_limit_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// handshake: stage 1 moves on when the output register is free
	// or its result is being taken in the same cycle
	// ---------------------------------------------------------------
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// ---------------------------------------------------------------
	// frame check: status 0 then 1, and both frames carry the same
	// humidity and temperature fields
	// ---------------------------------------------------------------
	assign check_ok = (in_s1.first_frame[31:30] == STATUS_FIRST)
		&& (in_s1.second_frame[31:30] == STATUS_SECOND)
		&& (in_s1.second_frame[29:16] == in_s1.first_frame[29:16])
		&& (in_s1.second_frame[15:2] == in_s1.first_frame[15:2]);

	// a tick only counts down while the countdown is nonzero
	assign countdown_dec = (countdown_q != 16'd0) ? countdown_q - 16'd1 : countdown_q;

	always_comb begin
		countdown_c     = countdown_q;
		read_next_c     = read_next_q;
		pending_c       = pending_q;
		valid_flag_c    = valid_flag_q;
		failure_count_c = failure_count_q;
		hum_raw_c       = hum_raw_q;
		temp_raw_c      = temp_raw_q;
		req_c           = REQ_NONE;
		fresh_c         = 1'b0;
		retry_c         = 1'b0;

		unique case (in_s1.func)
			FUNC_TICK: begin
				countdown_c = countdown_dec;
				// timer ran out and no bus operation outstanding
				if (countdown_dec == 16'd0 && !pending_q) begin
					req_c     = read_next_q ? REQ_READ : REQ_MEASURE;
					pending_c = 1'b1;
				end
			end
			FUNC_MEASURE_DONE: begin
				// stray completions are ignored
				if (pending_q && !read_next_q) begin
					if (in_s1.bus_status) begin
						retry_c = 1'b1;
					end else begin
						read_next_c = 1'b1;
						pending_c   = 1'b0;
						countdown_c = measure_delay_q;
					end
				end
			end
			FUNC_READ_DONE: begin
				if (pending_q && read_next_q) begin
					if (in_s1.bus_status) begin
						retry_c = 1'b1;
					end else begin
						// first frame fields are kept even when the check fails
						hum_raw_c  = in_s1.first_frame[29:16];
						temp_raw_c = in_s1.first_frame[15:2];
						if (!check_ok) begin
							retry_c = 1'b1;
						end else begin
							valid_flag_c    = 1'b1;
							failure_count_c = '0;
							read_next_c     = 1'b0;
							pending_c       = 1'b0;
							countdown_c     = wait_delay_q;
							fresh_c         = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		// retry path: back off, restart with the measure command and
		// count the failure against a valid reading
		if (retry_c) begin
			countdown_c = retry_delay_q;
			read_next_c = 1'b0;
			pending_c   = 1'b0;
			if (valid_flag_q) begin
				if (failure_count_q >= retry_limit_q) begin
					valid_flag_c = 1'b0;
				end
				if (failure_count_q != FAIL_MAX) begin
					failure_count_c = failure_count_q + 8'd1;
				end
			end
		end
	end

	// conversion to tenths from the reading as it stands after this request
	assign reading_c.valid    = valid_flag_c;
	assign reading_c.hum_raw  = hum_raw_c;
	assign reading_c.temp_raw = temp_raw_c;

	hspc_scale u_scale (
		.reading            (reading_c),
		.humidity_tenths    (hum_tenths_c),
		.temperature_tenths (temp_tenths_c)
	);

	assign result_c.request            = req_c;
	assign result_c.new_reading        = fresh_c;
	assign result_c.reading_valid      = valid_flag_c;
	assign result_c.humidity_tenths    = hum_tenths_c;
	assign result_c.temperature_tenths = temp_tenths_c;

	// ---------------------------------------------------------------
	// state update, one request per advance
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q     <= '0;
			read_next_q     <= 1'b0;
			pending_q       <= 1'b0;
			valid_flag_q    <= 1'b0;
			failure_count_q <= '0;
			hum_raw_q       <= '0;
			temp_raw_q      <= '0;
		end else if (advance) begin
			countdown_q     <= countdown_c;
			read_next_q     <= read_next_c;
			pending_q       <= pending_c;
			valid_flag_q    <= valid_flag_c;
			failure_count_q <= failure_count_c;
			hum_raw_q       <= hum_raw_c;
			temp_raw_q      <= temp_raw_c;
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= result_c;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

`ifndef SYNTH
	// a completed reading is always reported as valid
	a_fresh_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.new_reading |-> out_s2.reading_valid)
		else $error("new reading reported without valid flag");

	// a fresh reading leaves the failure count cleared
	a_fresh_clears_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.new_reading |-> failure_count_q == 8'd0)
		else $error("failure count not cleared by fresh reading");

	// any bus operation issued leaves a pending operation behind
	a_req_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_c != REQ_NONE |=> pending_q)
		else $error("bus operation issued without pending mark");

	// an invalid reading reads as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !out_s2.reading_valid |->
		out_s2.humidity_tenths == 10'd0 && out_s2.temperature_tenths == 12'sd0)
		else $error("invalid reading not zeroed");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import hspc_pkg::*;

	// item code that the block ignores like a stray completion
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 20;
	localparam int SHOWN_ERRORS = 10;

	// tracks the poll state and the readings it must produce
	class sensor_poll_checker;
		logic [15:0] retry_ticks   = RETRY_DELAY_RST;
		logic [15:0] measure_ticks = MEASURE_DELAY_RST;
		logic [15:0] hold_ticks    = WAIT_DELAY_RST;
		logic [7:0]  fail_limit    = RETRY_LIMIT_RST;

		logic [15:0]      countdown = '0;
		logic             read_next = 1'b0;
		logic             pending   = 1'b0;
		logic             valid     = 1'b0;
		logic [7:0]       fail_count = '0;
		logic [RAW_W-1:0] hum_raw   = '0;
		logic [RAW_W-1:0] temp_raw  = '0;

		out_t due_reports[$];
		int   errors = 0;

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_RETRY_DELAY:   retry_ticks   = value[15:0];
				REG_MEASURE_DELAY: measure_ticks = value[15:0];
				REG_WAIT_DELAY:    hold_ticks    = value[15:0];
				REG_RETRY_LIMIT:   fail_limit    = value[7:0];
				default: ;
			endcase
		endfunction

		function void fail_retry();
			countdown = retry_ticks;
			read_next = 1'b0;
			pending   = 1'b0;
			if (valid) begin
				if (fail_count >= fail_limit)
					valid = 1'b0;
				if (fail_count != FAIL_MAX)
					fail_count = fail_count + 8'd1;
			end
		endfunction

		function void note_request(in_t req);
			out_t        rep;
			logic [31:0] hum_t;
			logic [31:0] temp_t;
			rep = '0;
			rep.request = REQ_NONE;
			case (req.func)
				FUNC_TICK: begin
					if (countdown != 16'd0)
						countdown = countdown - 16'd1;
					if (countdown == 16'd0 && !pending) begin
						rep.request = read_next ? REQ_READ : REQ_MEASURE;
						pending = 1'b1;
					end
				end
				FUNC_MEASURE_DONE: begin
					if (pending && !read_next) begin
						if (req.bus_status)
							fail_retry();
						else begin
							read_next = 1'b1;
							pending   = 1'b0;
							countdown = measure_ticks;
						end
					end
				end
				FUNC_READ_DONE: begin
					if (pending && read_next) begin
						if (req.bus_status)
							fail_retry();
						else begin
							// first frame fields are kept even if the check fails
							hum_raw  = req.first_frame[29:16];
							temp_raw = req.first_frame[15:2];
							if (req.first_frame[31:30] != STATUS_FIRST ||
							    req.second_frame[31:30] != STATUS_SECOND ||
							    req.second_frame[29:16] != hum_raw ||
							    req.second_frame[15:2] != temp_raw)
								fail_retry();
							else begin
								valid      = 1'b1;
								fail_count = '0;
								read_next  = 1'b0;
								pending    = 1'b0;
								countdown  = hold_ticks;
								rep.new_reading = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
			rep.reading_valid = valid;
			if (valid) begin
				hum_t  = 32'(hum_raw) * 32'(HUM_SCALE) / 32'(FIELD_MAX);
				temp_t = 32'(temp_raw) * 32'(TEMP_SCALE) / 32'(FIELD_MAX) - 32'(TEMP_OFFSET);
				rep.humidity_tenths    = hum_t[9:0];
				rep.temperature_tenths = temp_t[11:0];
			end
			due_reports.push_back(rep);
		endfunction

		function void check_reading(out_t got);
			out_t want;
			logic bad;
			if (due_reports.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("result with nothing outstanding: req %0d hum %0d",
						got.request, got.humidity_tenths);
				return;
			end
			want = due_reports.pop_front();
			bad = (got.request !== want.request) ||
				(got.new_reading !== want.new_reading) ||
				(got.reading_valid !== want.reading_valid) ||
				(got.humidity_tenths !== want.humidity_tenths) ||
				(got.temperature_tenths !== want.temperature_tenths);
			if (bad) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display({"reading mismatch (exp/got): req %0d/%0d new %0b/%0b ",
						"valid %0b/%0b hum %0d/%0d temp %0d/%0d"},
						want.request, got.request, want.new_reading, got.new_reading,
						want.reading_valid, got.reading_valid,
						want.humidity_tenths, got.humidity_tenths,
						$signed(want.temperature_tenths), $signed(got.temperature_tenths));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// no random idling on either side while set
	logic calm = 1'b0;
	int   cycle_count = 0;

	sensor_poll_checker sb;

	humidity_sensor_poll_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: check every accepted reading, stall the receiver at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reading(out_data);
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic logic [31:0] make_frame(logic [1:0] status, logic [13:0] hum,
		logic [13:0] temp, logic [1:0] tail);
		return {status, hum, temp, tail};
	endfunction

	function automatic in_t poll_item(logic [1:0] func, logic err, logic [31:0] f1,
		logic [31:0] f2);
		in_t item;
		item.func         = func;
		item.bus_status   = err;
		item.first_frame  = f1;
		item.second_frame = f2;
		return item;
	endfunction

	// raw field with a bias toward both ends of the range
	function automatic logic [13:0] pick_raw();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return FIELD_MAX;
		return 14'($urandom_range(0, 16383));
	endfunction

	// next request: mostly the one the poll state is waiting for, some noise
	function automatic in_t next_poll_item(int fail_pct);
		in_t         item;
		logic [13:0] hum;
		logic [13:0] temp;
		logic [1:0]  bad_status;
		item.func         = FUNC_TICK;
		item.bus_status   = 1'($urandom_range(0, 1));
		item.first_frame  = $urandom;
		item.second_frame = $urandom;
		if ($urandom_range(0, 99) < 10)
			item.func = 2'($urandom_range(0, 3));
		else if (!sb.pending)
			item.func = FUNC_TICK;
		else if (!sb.read_next) begin
			item.func       = FUNC_MEASURE_DONE;
			item.bus_status = ($urandom_range(0, 99) < fail_pct);
		end else begin
			item.func       = FUNC_READ_DONE;
			item.bus_status = ($urandom_range(0, 199) < fail_pct);
			hum  = pick_raw();
			temp = pick_raw();
			item.first_frame  = make_frame(STATUS_FIRST, hum, temp, 2'($urandom_range(0, 3)));
			item.second_frame = make_frame(STATUS_SECOND, hum, temp, 2'($urandom_range(0, 3)));
			// break the frame pair in one of four ways
			if ($urandom_range(0, 99) < fail_pct) begin
				case ($urandom_range(0, 3))
					0: item.first_frame[31:30] = 2'($urandom_range(1, 3));
					1: begin
						bad_status = 2'($urandom_range(0, 2));
						if (bad_status == STATUS_SECOND)
							bad_status = 2'd3;
						item.second_frame[31:30] = bad_status;
					end
					2: item.second_frame[29:16] ^= 14'($urandom_range(1, 16383));
					default: item.second_frame[15:2] ^= 14'($urandom_range(1, 16383));
				endcase
			end
		end
		return item;
	endfunction

	// present one request, with a random one-cycle gap in front, and wait for acceptance
	task automatic push_request(in_t req);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= req;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(req);
	endtask

	// drop valid and wait until every reading has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_delays(logic [15:0] retry_ticks, logic [15:0] measure_ticks,
		logic [15:0] hold_ticks, logic [7:0] fail_limit);
		apb_write(REG_RETRY_DELAY, 32'(retry_ticks));
		apb_write(REG_MEASURE_DELAY, 32'(measure_ticks));
		apb_write(REG_WAIT_DELAY, 32'(hold_ticks));
		apb_write(REG_RETRY_LIMIT, 32'(fail_limit));
	endtask

	task automatic run_phase(int count, int fail_pct);
		for (int i = 0; i < count; i++)
			push_request(next_poll_item(fail_pct));
		settle();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults for delays and limit
		run_phase(150, 30);

		// directed walk with all delays zero and a limit of one
		program_delays(16'd0, 16'd0, 16'd0, 8'd1);
		// unused code and a stray read completion
		push_request(poll_item(FUNC_UNUSED, 1'b1, '1, '1));
		push_request(poll_item(FUNC_READ_DONE, 1'b0,
			make_frame(STATUS_FIRST, 14'd5, 14'd5, 2'd0),
			make_frame(STATUS_SECOND, 14'd5, 14'd5, 2'd0)));
		// measure request, then a tick while it is outstanding
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b1, '1, '1));
		// completion of the wrong kind, then a bus error on the measure
		push_request(poll_item(FUNC_READ_DONE, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b1, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b0, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b0, '0, '0));
		// good read at the low end of both fields
		push_request(poll_item(FUNC_READ_DONE, 1'b0,
			make_frame(STATUS_FIRST, 14'd0, 14'd0, 2'd0),
			make_frame(STATUS_SECOND, 14'd0, 14'd0, 2'd3)));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b0, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		// good read at the high end of both fields
		push_request(poll_item(FUNC_READ_DONE, 1'b0,
			make_frame(STATUS_FIRST, FIELD_MAX, FIELD_MAX, 2'd3),
			make_frame(STATUS_SECOND, FIELD_MAX, FIELD_MAX, 2'd0)));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b0, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		// wrong status in the verifying frame: fields stored, failure counted
		push_request(poll_item(FUNC_READ_DONE, 1'b0,
			make_frame(STATUS_FIRST, 14'h2000, 14'h1234, 2'd1),
			make_frame(2'd2, 14'h2000, 14'h1234, 2'd1)));
		// second failure at the limit drops the reading
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b1, '0, '0));
		// bus error on the read while invalid
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_MEASURE_DONE, 1'b0, '0, '0));
		push_request(poll_item(FUNC_TICK, 1'b0, '0, '0));
		push_request(poll_item(FUNC_READ_DONE, 1'b1,
			make_frame(STATUS_FIRST, 14'd7, 14'd7, 2'd0),
			make_frame(STATUS_SECOND, 14'd7, 14'd7, 2'd0)));
		settle();

		// zero limit: the first failure drops the reading
		program_delays(16'd0, 16'd0, 16'd0, 8'd0);
		run_phase(200, 30);

		// short delays, no idling on either side
		calm <= 1'b1;
		program_delays(16'd3, 16'd2, 16'd5, 8'd2);
		run_phase(250, 25);
		calm <= 1'b0;

		// largest delays and limit
		program_delays(16'hffff, 16'hffff, 16'hffff, 8'hff);
		run_phase(40, 30);

		program_delays(16'd1, 16'd1, 16'd1, 8'd3);
		run_phase(200, 40);

		// one good reading, then a long run of failures to saturate the count
		program_delays(16'd0, 16'd0, 16'd0, 8'hff);
		while (!sb.valid)
			push_request(next_poll_item(0));
		run_phase(620, 100);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
